FILE: sv/dmah_pkg.sv
// Shared types, constants and AES helper functions for the Davies-Meyer AES-128 hash.
// Used by dmah_front, dmah_core and davies_meyer_aes128_hash; depends on nothing.
package dmah_pkg;

    localparam int BLK_BYTES  = 16;
    localparam int BLK_BITS   = 128;
    localparam int NUM_ROUNDS = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    // One classified message block: the zero-filled AES key and its last mark.
    typedef struct packed {
        logic [BLK_BITS-1:0] key;
        logic                last;
    } t_blk;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX[a];
    endfunction

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // MixColumns on one column, byte 0 in bits 31:24.
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, t;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        t  = a0 ^ a1 ^ a2 ^ a3;
        return {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
                a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
    endfunction

endpackage

FILE: sv/davies_meyer_aes128_hash.sv
// Top level of the Davies-Meyer hash over AES-128: block queue, round engine, result register.
// Depends on dmah_pkg, dmah_front and dmah_core.
//
//   Channel   Direction  Handshake          Payload
//   blocks    in         i_push / o_full    i_msg_hi, i_msg_lo, i_byte_count, i_last_block
//   hashes    out        i_pop / o_empty    o_chain_hi, o_chain_lo, o_first_hash, o_final_hash
//
// In the round engine each block is first loaded as the chain XOR key, then runs the ten
// AES rounds through a single shared round unit, whose key schedule runs alongside.
// The chaining value feeds the next block, so blocks go through the engine one after another.
// A four-entry queue in front accepts requests while the engine works, and the result register
// holds a finished hash until it is popped; the engine waits in its last round while it is full.
// Reset (i_rst_n low at a clock edge) empties the queue and result register, zeroes the chain
// and sets the first-block flag.
module davies_meyer_aes128_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_msg_hi,
    input  logic [63:0] i_msg_lo,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last_block,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_chain_hi,
    output logic [63:0] o_chain_lo,
    output logic        o_first_hash,
    output logic        o_final_hash
);

    dmah_pkg::t_blk                w_blk;
    logic                          w_valid, w_take, w_done, w_first, w_last, w_out_free;
    logic [dmah_pkg::BLK_BITS-1:0] w_hash;
    logic                          r_out_valid;
    logic [dmah_pkg::BLK_BITS-1:0] r_out_hash;
    logic                          r_out_first, r_out_last;

    dmah_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_msg_hi     (i_msg_hi),
        .i_msg_lo     (i_msg_lo),
        .i_byte_count (i_byte_count),
        .i_last_block (i_last_block),
        .o_full       (o_full),
        .o_valid      (w_valid),
        .o_blk        (w_blk),
        .i_take       (w_take)
    );

    dmah_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_blk      (w_blk),
        .o_take     (w_take),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_hash     (w_hash),
        .o_first    (w_first),
        .o_last     (w_last)
    );

    // The result register frees up in the same cycle its request is popped.
    assign w_out_free = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_hash  <= w_hash;
            r_out_first <= w_first;
            r_out_last  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_chain_hi   = r_out_hash[127:64];
    assign o_chain_lo   = r_out_hash[63:0];
    assign o_first_hash = r_out_first;
    assign o_final_hash = r_out_last;

endmodule

FILE: sv/dmah_front.sv
// Front part: zero-fills each message block past its byte count and queues it.
// Depends on dmah_pkg.
module dmah_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [63:0]                   i_msg_hi,
    input  logic [63:0]                   i_msg_lo,
    input  logic [4:0]                    i_byte_count,
    input  logic                          i_last_block,
    output logic                          o_full,
    output logic                          o_valid,
    output dmah_pkg::t_blk                o_blk,
    input  logic                          i_take
);

    dmah_pkg::t_blk                  r_mem [dmah_pkg::QUEUE_DEPTH];
    logic [dmah_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [dmah_pkg::QPTR_W:0]       r_count;
    dmah_pkg::t_blk                  w_blk;
    logic                            w_push, w_pop;

    // Byte i is kept when i is below the count; counts of 16 and above keep all.
    always_comb begin
        logic [dmah_pkg::BLK_BITS-1:0] raw;
        raw = {i_msg_hi, i_msg_lo};
        for (int i = 0; i < dmah_pkg::BLK_BYTES; i++) begin
            w_blk.key[dmah_pkg::BLK_BITS-1-8*i -: 8] =
                (5'(i) < i_byte_count) ? raw[dmah_pkg::BLK_BITS-1-8*i -: 8] : 8'h00;
        end
        w_blk.last = i_last_block;
    end

    assign o_full  = (r_count == (dmah_pkg::QPTR_W+1)'(dmah_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_blk   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/dmah_core.sv
// Back part: one AES-128 round per cycle, with the last round held until the output is free;
// key expanded on the fly, Davies-Meyer feed-forward, chaining state. Depends on dmah_pkg.
module dmah_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dmah_pkg::t_blk                i_blk,
    output logic                          o_take,
    input  logic                          i_out_free,
    output logic                          o_done,
    output logic [dmah_pkg::BLK_BITS-1:0] o_hash,
    output logic                          o_first,
    output logic                          o_last
);

    logic                          r_busy;
    logic [3:0]                    r_round;
    logic [dmah_pkg::BLK_BITS-1:0] r_state, r_key, r_chain;
    logic [7:0]                    r_rc;
    logic                          r_first, r_last;
    logic [dmah_pkg::BLK_BITS-1:0] w_next_key, w_round_out, w_sub;
    logic                          w_final;

    // Next round key from the current one.
    always_comb begin
        logic [31:0] t, w0, w1, w2, w3;
        t  = {dmah_pkg::sbox(r_key[23:16]) ^ r_rc, dmah_pkg::sbox(r_key[15:8]),
              dmah_pkg::sbox(r_key[7:0]), dmah_pkg::sbox(r_key[31:24])};
        w0 = r_key[127:96] ^ t;
        w1 = r_key[95:64] ^ w0;
        w2 = r_key[63:32] ^ w1;
        w3 = r_key[31:0] ^ w2;
        w_next_key = {w0, w1, w2, w3};
    end

    // SubBytes and ShiftRows, then MixColumns on all but the last round, then AddRoundKey.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_sub[dmah_pkg::BLK_BITS-1-8*(c*4+i) -: 8] =
                    dmah_pkg::sbox(r_state[dmah_pkg::BLK_BITS-1-8*(((c+i)%4)*4+i) -: 8]);
            end
        end
        w_round_out = w_sub;
        if (r_round != 4'(dmah_pkg::NUM_ROUNDS)) begin
            for (int c = 0; c < 4; c++) begin
                w_round_out[dmah_pkg::BLK_BITS-1-32*c -: 32] =
                    dmah_pkg::mix_col(w_sub[dmah_pkg::BLK_BITS-1-32*c -: 32]);
            end
        end
        w_round_out = w_round_out ^ w_next_key;
    end

    assign w_final = r_busy && (r_round == 4'(dmah_pkg::NUM_ROUNDS)) && i_out_free;
    assign o_take  = !r_busy && i_valid;
    assign o_done  = w_final;
    assign o_hash  = w_round_out ^ r_chain;
    assign o_first = r_first;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_state <= r_chain ^ i_blk.key;
            r_key   <= i_blk.key;
            r_last  <= i_blk.last;
            r_rc    <= 8'h01;
        end else if (r_busy && r_round != 4'(dmah_pkg::NUM_ROUNDS)) begin
            r_state <= w_round_out;
            r_key   <= w_next_key;
            r_rc    <= dmah_pkg::xtime(r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_chain <= '0;
            r_first <= 1'b1;
        end else begin
            if (o_take) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (w_final) begin
                r_busy  <= 1'b0;
                r_chain <= r_last ? '0 : o_hash;
                r_first <= r_last;
            end else if (r_busy && r_round != 4'(dmah_pkg::NUM_ROUNDS)) begin
                r_round <= r_round + 4'd1;
            end
        end
    end

endmodule

FILE: verif/davies_meyer_aes128_hash_test.sv
// Self-checking test of davies_meyer_aes128_hash: directed and random message blocks.
// Depends on dmah_pkg (S-box table) and the davies_meyer_aes128_hash RTL.
module davies_meyer_aes128_hash_test;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        first;
        logic        final_mark;
    } t_hash;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [63:0] i_msg_hi;
    logic [63:0] i_msg_lo;
    logic [4:0]  i_byte_count;
    logic        i_last_block;
    logic        o_empty;
    logic        i_pop;
    logic [63:0] o_chain_hi;
    logic [63:0] o_chain_lo;
    logic        o_first_hash;
    logic        o_final_hash;

    // Predictor state: the chaining value and the start-of-message flag.
    logic [127:0] chain_state;
    logic         first_state;
    t_hash        hash_queue[$];

    int  send_idle_pct;
    int  pop_stall_pct;
    int  quiet_cycles;
    bit  failed;

    localparam int WATCHDOG_LIMIT = 2000;

    davies_meyer_aes128_hash uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block sits in bits 127-8i : 120-8i.
    function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                      input logic [127:0] pt);
        logic [7:0] k[16];
        logic [7:0] s[16];
        logic [7:0] u[16];
        logic [7:0] t[4];
        logic [7:0] rcon;
        logic [7:0] r0, x, a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            k[i] = key[127-8*i -: 8];
            s[i] = pt[127-8*i -: 8] ^ k[i];
        end
        rcon = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            // Next round key, computed on the fly.
            r0 = k[12];
            t[0] = dmah_pkg::SBOX[k[13]] ^ rcon;
            t[1] = dmah_pkg::SBOX[k[14]];
            t[2] = dmah_pkg::SBOX[k[15]];
            t[3] = dmah_pkg::SBOX[r0];
            rcon = gf_double(rcon);
            for (int w = 0; w < 4; w++)
                for (int j = 0; j < 4; j++) begin
                    k[w*4+j] = k[w*4+j] ^ t[j];
                    t[j] = k[w*4+j];
                end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    u[c*4+i] = dmah_pkg::SBOX[s[((c+i)&3)*4+i]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    u[c*4]   = a0 ^ x ^ gf_double(a0 ^ a1);
                    u[c*4+1] = a1 ^ x ^ gf_double(a1 ^ a2);
                    u[c*4+2] = a2 ^ x ^ gf_double(a2 ^ a3);
                    u[c*4+3] = a3 ^ x ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = u[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // Works out the hash of one accepted block and advances the chain.
    task automatic predict_hash(input logic [63:0] hi, input logic [63:0] lo,
                                input logic [4:0] cnt, input logic last);
        logic [127:0] key;
        logic [127:0] nxt;
        int n;
        t_hash h;
        n = (cnt > 16) ? 16 : cnt;
        key = {hi, lo};
        for (int i = n; i < 16; i++) key[127-8*i -: 8] = 8'h00;
        nxt = aes128_encrypt(key, chain_state) ^ chain_state;
        h.hi = nxt[127:64];
        h.lo = nxt[63:0];
        h.first = first_state;
        h.final_mark = last;
        hash_queue.push_back(h);
        chain_state = last ? '0 : nxt;
        first_state = last;
    endtask

    // Sends one request, with an optional random idle gap before it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_msg_hi     <= hi;
        i_msg_lo     <= lo;
        i_byte_count <= cnt;
        i_last_block <= last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_hash(hi, lo, cnt, last);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Draws a count: mostly full blocks, some short, some above sixteen.
    function automatic logic [4:0] rand_count();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 5'd16;
        if (p < 85) return 5'($urandom_range(15));
        return 5'($urandom_range(31));
    endfunction

    task automatic wait_drained();
        i_push <= 1'b0;
        while (hash_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Output side: pop with random stalls and compare each hash.
    always @(posedge i_clk) begin
        t_hash exp_h;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (hash_queue.size() == 0) begin
                    $display("%0t: unexpected hash %h_%h", $time, o_chain_hi, o_chain_lo);
                    failed = 1'b1;
                end else begin
                    exp_h = hash_queue.pop_front();
                    if (o_chain_hi !== exp_h.hi || o_chain_lo !== exp_h.lo) begin
                        $display("%0t: chain expected %h_%h actual %h_%h", $time,
                                 exp_h.hi, exp_h.lo, o_chain_hi, o_chain_lo);
                        failed = 1'b1;
                    end
                    if (o_first_hash !== exp_h.first) begin
                        $display("%0t: first_hash expected %b actual %b", $time,
                                 exp_h.first, o_first_hash);
                        failed = 1'b1;
                    end
                    if (o_final_hash !== exp_h.final_mark) begin
                        $display("%0t: final_hash expected %b actual %b", $time,
                                 exp_h.final_mark, o_final_hash);
                        failed = 1'b1;
                    end
                end
            end
            i_pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog: counts cycles in which no request or hash moves.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed: field extremes, every count class, empty message, one-block
    // and multi-block messages, zero and short blocks inside a message.
    task automatic test_directed();
        send_block('0, '0, 5'd0, 1'b1);
        send_block('1, '1, 5'd16, 1'b1);
        send_block('1, '1, 5'd31, 1'b1);
        send_block('1, '1, 5'd17, 1'b0);
        send_block('1, '1, 5'd0, 1'b0);
        send_block('1, '1, 5'd1, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd7, 1'b1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16, 1'b0);
        send_block('0, '1, 5'd16, 1'b1);
        for (int c = 2; c < 16; c += 3) send_block(rand64(), rand64(), 5'(c), 1'b0);
        send_block(rand64(), rand64(), 5'd12, 1'b1);
    endtask

    // Random messages of one to eight blocks, plus a few loose blocks.
    task automatic test_random(input int blocks, input int idle, input int stall);
        int sent;
        int len;
        send_idle_pct = idle;
        pop_stall_pct = stall;
        sent = 0;
        while (sent < blocks) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 1);
            for (int b = 0; b < len; b++)
                send_block(rand64(), rand64(),
                           (b == len-1) ? rand_count() : 5'd16, b == len-1);
            sent += len;
            if ($urandom_range(19) == 0) begin
                send_block(rand64(), rand64(), rand_count(), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
        chain_state   = '0;
        first_state   = 1'b1;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_msg_hi      = '0;
        i_msg_lo      = '0;
        i_byte_count  = '0;
        i_last_block  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 0, 0);
        test_random(300, 66, 0);
        test_random(300, 0, 66);
        test_random(300, 27, 27);
        // Close any message left open by a loose block.
        send_block(rand64(), rand64(), 5'd16, 1'b1);
        wait_drained();

        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
